// ===== sv/gca_pkg.sv =====
// ----------------------------------------------------------------------------
// gca_pkg
// Shared types and constants for the graph connectivity analyzer.
// ----------------------------------------------------------------------------
`default_nettype none

package gca_pkg;

    localparam int MAX_V_DEF = 64;
    localparam int VAL_W     = 7;
    localparam logic [VAL_W-1:0] VC_RESET = 7'd64;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_ADD    = 3'd1,
        REQ_COMP   = 3'd2,
        REQ_SIZES  = 3'd3,
        REQ_BRIDGE = 3'd4,
        REQ_CUT    = 3'd5
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_WR,
        S_HCLR,
        S_ROOT,
        S_ROW,
        S_SCAN,
        S_BACK,
        S_POP,
        S_HIST_WR,
        S_FIN,
        S_SZ_RD,
        S_SZ_CHK,
        S_SZ_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/gca_ram.sv =====
// ----------------------------------------------------------------------------
// gca_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/graph_connectivity_analyzer.sv =====
// ----------------------------------------------------------------------------
// graph_connectivity_analyzer
// Adjacency-matrix graph store with component, size, bridge and cut-vertex
// queries, each walked depth first with a stack held in RAM.
//
// Input channel (in_valid/in_stall): one item per request. Clear drops all
// row valid bits at once; add reads the row and then writes it back.
// A query walks the graph: one adjacency row read per stack push or pop,
// one scan step per neighbor found, and a discovery-time read per back
// edge in the Tarjan walks; the size query adds a histogram clear of V
// entries and a V-entry sweep. The adjacency RAM read port sets the pace.
// in_stall is high while a request is in progress.
// Output channel (out_valid/out_stall): results sit in an output register;
// a stalled result holds and the walk waits at its emit step. A size query
// gives one item per component, smallest first, last set on the final one.
// Config (cfg_valid/cfg_ready/cfg_data): vertex_count, always ready; write
// only while idle. Reset: graph empty, vertex_count 64, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_connectivity_analyzer #(
    parameter int MAX_V = gca_pkg::MAX_V_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] req_type,
    input  wire logic [6:0] vertex_a,
    input  wire logic [6:0] vertex_b,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [6:0]      result_value,
    output logic            none_found,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data
);

    localparam int VW  = $clog2(MAX_V);      // vertex index
    localparam int CW  = $clog2(MAX_V + 1);  // counts up to MAX_V
    localparam int SEW = 2 * VW + CW;        // stack entry {vertex, next, parent}

    // first set bit, {found, index}
    function automatic logic [VW:0] find_first(input logic [MAX_V-1:0] m);
        logic [VW:0] r;
        r = '0;
        for (int i = MAX_V - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = {1'b1, VW'(i)};
            end
        end
        return r;
    endfunction

    // ---------------- registers ----------------
    gca_pkg::state_t state_reg, state_next;
    gca_pkg::req_t   mode_reg, mode_next;
    logic [MAX_V-1:0] seen_reg, seen_next;
    logic [MAX_V-1:0] cut_reg, cut_next;
    logic [MAX_V-1:0] row_valid_reg, row_valid_next;
    logic [6:0]       vc_reg, vc_next;
    logic [VW-1:0]    cur_u_reg, cur_u_next;
    logic [CW-1:0]    cur_next_reg, cur_next_next;
    logic [VW-1:0]    par_reg, par_next;
    logic [CW-1:0]    sp_reg, sp_next;
    logic [CW-1:0]    cur_low_reg, cur_low_next;
    logic [CW-1:0]    time_reg, time_next;
    logic [CW-1:0]    children_reg, children_next;
    logic [CW-1:0]    size_reg, size_next;
    logic [CW-1:0]    comps_reg, comps_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    sz_idx_reg, sz_idx_next;
    logic [CW-1:0]    rep_reg, rep_next;
    logic [CW-1:0]    rep_cnt_reg, rep_cnt_next;
    logic [CW-1:0]    emitted_reg, emitted_next;
    logic [VW-1:0]    add_row_reg, add_row_next;
    logic [VW-1:0]    add_col_reg, add_col_next;
    logic             out_valid_reg, out_valid_next;
    logic [6:0]       result_value_reg, result_value_next;
    logic             none_found_reg, none_found_next;
    logic             last_reg, last_next;

    // ---------------- memories ----------------
    logic             adj_we, adj_re;
    logic [VW-1:0]    adj_waddr, adj_raddr;
    logic [MAX_V-1:0] adj_wdata, adj_rdata;
    logic             stk_we, stk_re;
    logic [VW-1:0]    stk_waddr, stk_raddr;
    logic [SEW-1:0]   stk_wdata, stk_rdata;
    logic             disc_we, disc_re;
    logic [VW-1:0]    disc_waddr, disc_raddr;
    logic [CW-1:0]    disc_wdata, disc_rdata;
    logic             low_we, low_re;
    logic [VW-1:0]    low_waddr, low_raddr;
    logic [CW-1:0]    low_wdata, low_rdata;
    logic             hist_we, hist_re;
    logic [CW-1:0]    hist_waddr, hist_raddr;
    logic [CW-1:0]    hist_wdata, hist_rdata;

    gca_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata)
    );

    gca_ram #(.WIDTH(SEW), .DEPTH(MAX_V)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    gca_ram #(.WIDTH(CW), .DEPTH(MAX_V)) u_disc (
        .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
        .re(disc_re), .raddr(disc_raddr), .rdata(disc_rdata)
    );

    gca_ram #(.WIDTH(CW), .DEPTH(MAX_V)) u_low (
        .clk(clk), .we(low_we), .waddr(low_waddr), .wdata(low_wdata),
        .re(low_re), .raddr(low_raddr), .rdata(low_rdata)
    );

    // component size histogram, indexed by size
    gca_ram #(.WIDTH(CW), .DEPTH(MAX_V + 1)) u_hist (
        .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
        .re(hist_re), .raddr(hist_raddr), .rdata(hist_rdata)
    );

    // ---------------- shared decode ----------------
    logic [CW-1:0]    n_act;
    logic             tarjan;
    logic             has_par;
    logic [MAX_V-1:0] row;
    logic [MAX_V-1:0] cand;
    logic [MAX_V-1:0] root_mask;
    logic [VW:0]      cand_ff, root_ff;
    logic             found, root_found, v_seen;
    logic [VW-1:0]    v_idx, root_idx;
    logic             out_free;
    logic             a_ok;
    logic             is_query;
    logic [VW-1:0]    pop_w, pop_par;
    logic [CW-1:0]    pop_next;
    logic             sz_last, rep_done;

    always_comb
    begin
        if (vc_reg == 7'd0)
        begin
            n_act = CW'(1);
        end
        else if (32'(vc_reg) > MAX_V)
        begin
            n_act = CW'(MAX_V);
        end
        else
        begin
            n_act = CW'(vc_reg);
        end
    end

    assign tarjan  = (mode_reg == gca_pkg::REQ_BRIDGE) || (mode_reg == gca_pkg::REQ_CUT);
    assign has_par = sp_reg > CW'(1);
    assign row     = adj_rdata & {MAX_V{row_valid_reg[cur_u_reg]}};

    // neighbor candidates from cur_next upward; Tarjan skips the parent,
    // the plain walk skips anything already seen
    always_comb
    begin
        for (int i = 0; i < MAX_V; i++)
        begin
            cand[i] = row[i] && (i >= int'(cur_next_reg)) && (i < int'(n_act)) &&
                      (tarjan ? !(has_par && (i == int'(par_reg))) : !seen_reg[i]);
            root_mask[i] = !seen_reg[i] && (i < int'(n_act));
        end
    end

    assign cand_ff    = find_first(cand);
    assign root_ff    = find_first(root_mask);
    assign found      = cand_ff[VW];
    assign v_idx      = cand_ff[VW-1:0];
    assign root_found = root_ff[VW];
    assign root_idx   = root_ff[VW-1:0];
    assign v_seen     = seen_reg[v_idx];
    assign out_free   = !out_valid_reg || !out_stall;
    assign a_ok       = (vertex_a != 7'd0) && (32'(vertex_a) <= MAX_V) &&
                        (vertex_b != 7'd0) && (32'(vertex_b) <= MAX_V);
    assign is_query   = (req_type == gca_pkg::REQ_COMP) || (req_type == gca_pkg::REQ_SIZES) ||
                        (req_type == gca_pkg::REQ_BRIDGE) || (req_type == gca_pkg::REQ_CUT);
    assign pop_w      = stk_rdata[SEW-1 -: VW];
    assign pop_next   = stk_rdata[VW +: CW];
    assign pop_par    = stk_rdata[VW-1:0];
    assign sz_last    = (emitted_reg + CW'(1)) == comps_reg;
    assign rep_done   = (rep_reg + CW'(1)) == rep_cnt_reg;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gca_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == gca_pkg::REQ_ADD && a_ok)
                    begin
                        state_next = gca_pkg::S_ADD_WR;
                    end
                    else if (req_type == gca_pkg::REQ_SIZES)
                    begin
                        state_next = gca_pkg::S_HCLR;
                    end
                    else if (is_query)
                    begin
                        state_next = gca_pkg::S_ROOT;
                    end
                end
            end
            gca_pkg::S_ADD_WR:  state_next = gca_pkg::S_IDLE;
            gca_pkg::S_HCLR:
            begin
                if (sz_idx_reg == n_act)
                begin
                    state_next = gca_pkg::S_ROOT;
                end
            end
            gca_pkg::S_ROOT:
            begin
                if (root_found)
                begin
                    state_next = gca_pkg::S_ROW;
                end
                else if (mode_reg == gca_pkg::REQ_SIZES)
                begin
                    state_next = gca_pkg::S_SZ_RD;
                end
                else
                begin
                    state_next = gca_pkg::S_FIN;
                end
            end
            gca_pkg::S_ROW:     state_next = gca_pkg::S_SCAN;
            gca_pkg::S_SCAN:
            begin
                if (found)
                begin
                    state_next = v_seen ? gca_pkg::S_BACK : gca_pkg::S_ROW;
                end
                else if (has_par)
                begin
                    state_next = gca_pkg::S_POP;
                end
                else if (mode_reg == gca_pkg::REQ_SIZES)
                begin
                    state_next = gca_pkg::S_HIST_WR;
                end
                else
                begin
                    state_next = gca_pkg::S_ROOT;
                end
            end
            gca_pkg::S_BACK:    state_next = gca_pkg::S_SCAN;
            gca_pkg::S_POP:     state_next = gca_pkg::S_ROW;
            gca_pkg::S_HIST_WR: state_next = gca_pkg::S_ROOT;
            gca_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = gca_pkg::S_IDLE;
                end
            end
            gca_pkg::S_SZ_RD:   state_next = gca_pkg::S_SZ_CHK;
            gca_pkg::S_SZ_CHK:
            begin
                state_next = (hist_rdata == '0) ? gca_pkg::S_SZ_RD : gca_pkg::S_SZ_EMIT;
            end
            gca_pkg::S_SZ_EMIT:
            begin
                if (out_free)
                begin
                    if (sz_last)
                    begin
                        state_next = gca_pkg::S_IDLE;
                    end
                    else if (rep_done)
                    begin
                        state_next = gca_pkg::S_SZ_RD;
                    end
                end
            end
            default:            state_next = gca_pkg::S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        mode_next         = mode_reg;
        seen_next         = seen_reg;
        cut_next          = cut_reg;
        row_valid_next    = row_valid_reg;
        vc_next           = cfg_valid ? cfg_data : vc_reg;
        cur_u_next        = cur_u_reg;
        cur_next_next     = cur_next_reg;
        par_next          = par_reg;
        sp_next           = sp_reg;
        cur_low_next      = cur_low_reg;
        time_next         = time_reg;
        children_next     = children_reg;
        size_next         = size_reg;
        comps_next        = comps_reg;
        count_next        = count_reg;
        sz_idx_next       = sz_idx_reg;
        rep_next          = rep_reg;
        rep_cnt_next      = rep_cnt_reg;
        emitted_next      = emitted_reg;
        add_row_next      = add_row_reg;
        add_col_next      = add_col_reg;
        out_valid_next    = out_valid_reg && out_stall;
        result_value_next = result_value_reg;
        none_found_next   = none_found_reg;
        last_next         = last_reg;

        adj_we = 1'b0;  adj_waddr = '0;  adj_wdata = '0;  adj_re = 1'b0;  adj_raddr = '0;
        stk_we = 1'b0;  stk_waddr = '0;  stk_wdata = '0;  stk_re = 1'b0;  stk_raddr = '0;
        disc_we = 1'b0; disc_waddr = '0; disc_wdata = '0; disc_re = 1'b0; disc_raddr = '0;
        low_we = 1'b0;  low_waddr = '0;  low_wdata = '0;  low_re = 1'b0;  low_raddr = '0;
        hist_we = 1'b0; hist_waddr = '0; hist_wdata = '0; hist_re = 1'b0; hist_raddr = '0;

        case (state_reg)
            gca_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == gca_pkg::REQ_CLEAR)
                    begin
                        row_valid_next = '0;
                    end
                    else if (req_type == gca_pkg::REQ_ADD)
                    begin
                        if (a_ok)
                        begin
                            adj_re       = 1'b1;
                            adj_raddr    = VW'(vertex_a - 7'd1);
                            add_row_next = VW'(vertex_a - 7'd1);
                            add_col_next = VW'(vertex_b - 7'd1);
                        end
                    end
                    else if (is_query)
                    begin
                        mode_next    = gca_pkg::req_t'(req_type);
                        seen_next    = '0;
                        cut_next     = '0;
                        time_next    = '0;
                        count_next   = '0;
                        comps_next   = '0;
                        emitted_next = '0;
                        sz_idx_next  = CW'(1);
                    end
                end
            end
            gca_pkg::S_ADD_WR:
            begin
                adj_we    = 1'b1;
                adj_waddr = add_row_reg;
                adj_wdata = (adj_rdata & {MAX_V{row_valid_reg[add_row_reg]}}) |
                            (MAX_V'(1) << add_col_reg);
                row_valid_next[add_row_reg] = 1'b1;
            end
            gca_pkg::S_HCLR:
            begin
                hist_we    = 1'b1;
                hist_waddr = sz_idx_reg;
                hist_wdata = '0;
                sz_idx_next = (sz_idx_reg == n_act) ? CW'(1) : sz_idx_reg + CW'(1);
            end
            gca_pkg::S_ROOT:
            begin
                if (root_found)
                begin
                    seen_next[root_idx] = 1'b1;
                    time_next     = time_reg + CW'(1);
                    cur_low_next  = time_reg + CW'(1);
                    cur_u_next    = root_idx;
                    cur_next_next = '0;
                    sp_next       = CW'(1);
                    children_next = '0;
                    size_next     = CW'(1);
                    adj_re        = 1'b1;
                    adj_raddr     = root_idx;
                    disc_we       = 1'b1;
                    disc_waddr    = root_idx;
                    disc_wdata    = time_reg + CW'(1);
                end
            end
            gca_pkg::S_SCAN:
            begin
                if (found)
                begin
                    if (!v_seen)
                    begin
                        // tree edge: park the current frame, descend into v
                        stk_we     = 1'b1;
                        stk_waddr  = VW'(sp_reg - CW'(1));
                        stk_wdata  = {cur_u_reg, CW'(v_idx) + CW'(1), par_reg};
                        low_we     = 1'b1;
                        low_waddr  = cur_u_reg;
                        low_wdata  = cur_low_reg;
                        disc_we    = 1'b1;
                        disc_waddr = v_idx;
                        disc_wdata = time_reg + CW'(1);
                        time_next     = time_reg + CW'(1);
                        cur_low_next  = time_reg + CW'(1);
                        par_next      = cur_u_reg;
                        cur_u_next    = v_idx;
                        cur_next_next = '0;
                        sp_next       = sp_reg + CW'(1);
                        seen_next[v_idx] = 1'b1;
                        size_next     = size_reg + CW'(1);
                        if (sp_reg == CW'(1))
                        begin
                            children_next = children_reg + CW'(1);
                        end
                        adj_re    = 1'b1;
                        adj_raddr = v_idx;
                    end
                    else
                    begin
                        // back edge: fetch its discovery time
                        disc_re       = 1'b1;
                        disc_raddr    = v_idx;
                        cur_next_next = CW'(v_idx) + CW'(1);
                    end
                end
                else if (has_par)
                begin
                    stk_re     = 1'b1;
                    stk_raddr  = VW'(sp_reg - CW'(2));
                    disc_re    = 1'b1;
                    disc_raddr = par_reg;
                    low_re     = 1'b1;
                    low_raddr  = par_reg;
                end
                else
                begin
                    // root finished
                    comps_next = comps_reg + CW'(1);
                    if (mode_reg == gca_pkg::REQ_CUT && children_reg > CW'(1))
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (mode_reg == gca_pkg::REQ_SIZES)
                    begin
                        hist_re    = 1'b1;
                        hist_raddr = size_reg;
                    end
                end
            end
            gca_pkg::S_BACK:
            begin
                if (disc_rdata < cur_low_reg)
                begin
                    cur_low_next = disc_rdata;
                end
            end
            gca_pkg::S_POP:
            begin
                if (mode_reg == gca_pkg::REQ_BRIDGE && cur_low_reg > disc_rdata)
                begin
                    count_next = count_reg + CW'(1);
                end
                // the root is judged by its child count instead
                if (mode_reg == gca_pkg::REQ_CUT && cur_low_reg >= disc_rdata &&
                    sp_reg > CW'(2) && !cut_reg[pop_w])
                begin
                    cut_next[pop_w] = 1'b1;
                    count_next      = count_reg + CW'(1);
                end
                cur_low_next  = (low_rdata < cur_low_reg) ? low_rdata : cur_low_reg;
                cur_u_next    = pop_w;
                cur_next_next = pop_next;
                par_next      = pop_par;
                sp_next       = sp_reg - CW'(1);
                adj_re        = 1'b1;
                adj_raddr     = pop_w;
            end
            gca_pkg::S_HIST_WR:
            begin
                hist_we    = 1'b1;
                hist_waddr = size_reg;
                hist_wdata = hist_rdata + CW'(1);
            end
            gca_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    result_value_next = (mode_reg == gca_pkg::REQ_COMP) ? 7'(comps_reg)
                                                                        : 7'(count_reg);
                    none_found_next   = tarjan && (count_reg == '0);
                    last_next         = 1'b1;
                end
            end
            gca_pkg::S_SZ_RD:
            begin
                hist_re    = 1'b1;
                hist_raddr = sz_idx_reg;
            end
            gca_pkg::S_SZ_CHK:
            begin
                rep_cnt_next = hist_rdata;
                rep_next     = '0;
                if (hist_rdata == '0)
                begin
                    sz_idx_next = sz_idx_reg + CW'(1);
                end
            end
            gca_pkg::S_SZ_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    result_value_next = 7'(sz_idx_reg);
                    none_found_next   = 1'b0;
                    last_next         = sz_last;
                    emitted_next      = emitted_reg + CW'(1);
                    rep_next          = rep_reg + CW'(1);
                    if (rep_done)
                    begin
                        sz_idx_next = sz_idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gca_pkg::S_IDLE;
            mode_reg      <= gca_pkg::REQ_COMP;
            seen_reg      <= '0;
            cut_reg       <= '0;
            row_valid_reg <= '0;
            vc_reg        <= gca_pkg::VC_RESET;
            sp_reg        <= '0;
            time_reg      <= '0;
            count_reg     <= '0;
            comps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            seen_reg      <= seen_next;
            cut_reg       <= cut_next;
            row_valid_reg <= row_valid_next;
            vc_reg        <= vc_next;
            sp_reg        <= sp_next;
            time_reg      <= time_next;
            count_reg     <= count_next;
            comps_reg     <= comps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_u_reg        <= cur_u_next;
        cur_next_reg     <= cur_next_next;
        par_reg          <= par_next;
        cur_low_reg      <= cur_low_next;
        children_reg     <= children_next;
        size_reg         <= size_next;
        sz_idx_reg       <= sz_idx_next;
        rep_reg          <= rep_next;
        rep_cnt_reg      <= rep_cnt_next;
        emitted_reg      <= emitted_next;
        add_row_reg      <= add_row_next;
        add_col_reg      <= add_col_next;
        result_value_reg <= result_value_next;
        none_found_reg   <= none_found_next;
        last_reg         <= last_next;
    end

    assign in_stall     = state_reg != gca_pkg::S_IDLE;
    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign none_found   = none_found_reg;
    assign last         = last_reg;
    assign cfg_ready    = 1'b1;

`ifndef SYNTHESIS
    // neighbor scan always has a frame on the stack
    a_scan_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gca_pkg::S_SCAN) |-> (sp_reg != '0))
        else $error("scan with empty stack");

    // a count never outgrows the active vertex set during a query
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != gca_pkg::S_IDLE && state_reg != gca_pkg::S_ADD_WR) |->
        (count_reg <= n_act && comps_reg <= n_act))
        else $error("count exceeds vertex count");

    // an accepted query holds off the input channel next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && is_query) |=> in_stall)
        else $error("query accepted without going busy");

    // stack pointer stays within the vertex set
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != gca_pkg::S_IDLE) |-> (sp_reg <= n_act))
        else $error("stack pointer out of range");
`endif

endmodule

`default_nettype wire
